/* hdl/cdjd_pkg.sv */
// shared types, constants and the month table for the julian day converter
package cdjd_pkg;

  localparam int unsigned IN_BYTES  = 8;
  localparam int unsigned OUT_BYTES = 8;

  // day length in microseconds is ODD << SHIFT
  localparam logic signed [24:0] DAY_ODD   = 25'sd10546875;
  localparam int unsigned        DAY_SHIFT = 13;

  localparam logic signed [63:0] HALF_DAY_US   = 64'sd43200000000;
  localparam logic signed [63:0] GREG_LIMIT_US = 64'sd198647424000000000;
  localparam logic signed [63:0] GAP_VALUE_US  = 64'sd198647467200000000;
  localparam logic signed [63:0] OUT_MAX       = 64'sd576460752303423487;
  localparam logic signed [63:0] OUT_MIN       = -64'sd576460752303423488;

  localparam logic [36:0] US_PER_HOUR = 37'd3600000000;
  localparam logic [31:0] US_PER_MIN  = 32'd60000000;
  localparam logic signed [37:0] US_PER_SEC = 38'sd1000000;

  localparam logic signed [16:0] YEAR_BIAS  = 17'sd4716;
  localparam logic signed [26:0] YEAR_MUL   = 27'sd1461;
  localparam logic signed [11:0] DAY_BIAS   = 12'sd1524;
  // floor(y/100) via reciprocal on a biased, non-negative year
  localparam logic signed [16:0] CENT_OFS   = 17'sd16400;
  localparam logic [31:0]        CENT_RECIP = 32'd41944;
  localparam logic signed [9:0]  CENT_BIAS  = 10'sd164;

  localparam logic [14:0] GAP_YEAR  = 15'd1582;
  localparam logic [3:0]  GAP_MONTH = 4'd10;
  localparam logic [4:0]  GAP_FIRST = 5'd5;
  localparam logic [4:0]  GAP_LAST  = 5'd14;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [19:0]        microsecond;
  } date_t;

  // front end result: whole day count, century correction, time of day
  typedef struct packed {
    logic signed [24:0] days;
    logic signed [9:0]  corr;
    logic signed [40:0] tod_us;
    logic               gap;
  } front_t;

  typedef struct packed {
    logic signed [63:0] base_us;
    logic signed [63:0] corr_us;
    logic               gap;
  } scale_t;

  typedef struct packed {
    logic [59:0] julian_day_us;
    logic        gap_date;
  } result_t;

  // floor(30.6001*(m+1)) with january/february as months 13/14
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd397;
      4'd1:    r = 9'd428;
      4'd2:    r = 9'd459;
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      default: r = 9'd489;
    endcase
    return r;
  endfunction

endpackage

/* hdl/cdjd_front.sv */
// stages one and two: date terms, century correction and time of day
module cdjd_front (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  cdjd_pkg::date_t      date,
  input  logic signed [16:0]   utc_off,
  output cdjd_pkg::front_t     front
);
  import cdjd_pkg::*;

  typedef struct packed {
    logic signed [26:0] year_term;
    logic signed [11:0] md_term;
    logic [31:0]        cent_prod;
    logic [36:0]        h_us;
    logic [31:0]        m_us;
    logic signed [37:0] s_us;
    logic [19:0]        us;
    logic               gap;
  } s1_t;

  s1_t    s1_r, s1_nxt;
  front_t s2_r, s2_nxt;

  logic               early;
  logic signed [15:0] ya;
  logic signed [16:0] yp;
  logic [15:0]        yu;
  logic signed [17:0] sdiff;
  logic signed [9:0]  cent;

  always_comb begin
    early = (date.month < 4'd3);
    ya    = early ? (16'(date.year) - 16'sd1) : 16'(date.year);
    yp    = 17'(ya) + YEAR_BIAS;
    yu    = 16'(17'(ya) + CENT_OFS);
    sdiff = 18'($signed({1'b0, date.second})) - 18'(utc_off);

    s1_nxt.year_term = 27'(yp) * YEAR_MUL;
    s1_nxt.md_term   = 12'($signed({1'b0, month_days(date.month)}))
                     + 12'($signed({1'b0, date.day})) - DAY_BIAS;
    s1_nxt.cent_prod = 32'(yu) * CENT_RECIP;
    s1_nxt.h_us      = 37'(date.hour) * US_PER_HOUR;
    s1_nxt.m_us      = 32'(date.minute) * US_PER_MIN;
    s1_nxt.s_us      = 38'(sdiff) * US_PER_SEC;
    s1_nxt.us        = date.microsecond;
    s1_nxt.gap       = (date.year == $signed(GAP_YEAR)) && (date.month == GAP_MONTH)
                     && (date.day >= GAP_FIRST) && (date.day <= GAP_LAST);
  end

  always_comb begin
    cent          = $signed(s1_r.cent_prod[31:22]) - CENT_BIAS;
    s2_nxt.days   = 25'(s1_r.year_term >>> 2) + 25'(s1_r.md_term);
    s2_nxt.corr   = 10'sd2 - cent + (cent >>> 2);
    s2_nxt.tod_us = 41'($signed({1'b0, s1_r.h_us})) + 41'($signed({1'b0, s1_r.m_us}))
                  + 41'(s1_r.s_us) + 41'($signed({1'b0, s1_r.us}));
    s2_nxt.gap    = s1_r.gap;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  assign front = s2_r;

endmodule

/* hdl/cdjd_scale.sv */
// stages three and four: scale days to microseconds and add time of day
module cdjd_scale (
  input  logic              clk,
  input  logic [1:0]        en,
  input  cdjd_pkg::front_t  front,
  output cdjd_pkg::scale_t  scale
);
  import cdjd_pkg::*;

  typedef struct packed {
    logic signed [48:0] day_prod;
    logic signed [33:0] corr_prod;
    logic signed [40:0] tod_us;
    logic               gap;
  } s3_t;

  s3_t    s3_r, s3_nxt;
  scale_t s4_r, s4_nxt;

  always_comb begin
    s3_nxt.day_prod  = 49'(front.days) * 49'(DAY_ODD);
    s3_nxt.corr_prod = 34'(front.corr) * 34'(DAY_ODD);
    s3_nxt.tod_us    = front.tod_us;
    s3_nxt.gap       = front.gap;
  end

  always_comb begin
    s4_nxt.base_us = (64'(s3_r.day_prod) <<< DAY_SHIFT) - HALF_DAY_US + 64'(s3_r.tod_us);
    s4_nxt.corr_us = 64'(s3_r.corr_prod) <<< DAY_SHIFT;
    s4_nxt.gap     = s3_r.gap;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s3_r <= s3_nxt;
    end
    if (en[1]) begin
      s4_r <= s4_nxt;
    end
  end

  assign scale = s4_r;

endmodule

/* hdl/cdjd_final.sv */
// stages five and six: gregorian correction, saturation and gap override
module cdjd_final (
  input  logic              clk,
  input  logic [1:0]        en,
  input  cdjd_pkg::scale_t  scale,
  output cdjd_pkg::result_t res
);
  import cdjd_pkg::*;

  typedef struct packed {
    logic signed [63:0] jd_us;
    logic               gap;
  } s5_t;

  s5_t     s5_r, s5_nxt;
  result_t s6_r, s6_nxt;
  logic signed [63:0] sat;

  always_comb begin
    s5_nxt.jd_us = (scale.base_us > GREG_LIMIT_US) ? (scale.base_us + scale.corr_us)
                                                   : scale.base_us;
    s5_nxt.gap   = scale.gap;
  end

  always_comb begin
    if (s5_r.gap) begin
      sat = GAP_VALUE_US;
    end else if (s5_r.jd_us > OUT_MAX) begin
      sat = OUT_MAX;
    end else if (s5_r.jd_us < OUT_MIN) begin
      sat = OUT_MIN;
    end else begin
      sat = s5_r.jd_us;
    end
    s6_nxt.julian_day_us = sat[59:0];
    s6_nxt.gap_date      = s5_r.gap;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s5_r <= s5_nxt;
    end
    if (en[1]) begin
      s6_r <= s6_nxt;
    end
  end

  assign res = s6_r;

endmodule

/* hdl/calendar_date_to_julian_day.sv */
// calendar date and time to julian day in signed microseconds, top level
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_data: utc_offset_seconds
//  in       in         in_tvalid / in_tready  in_tdata: date and time fields
//  out      out        out_tvalid / out_tready out_tdata, out_tuser
//
// six register stages, one beat in and one beat out per cycle while out_tready is high.
// each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds every stage behind it without loss.
// reset clears the stage valid bits and the utc offset; cfg_ready is always high.
module calendar_date_to_julian_day (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,    // utc_offset_seconds
  input  logic        in_tvalid,
  output logic        in_tready,
  // year[14:0] month[18:15] day[23:19] hour[28:24] minute[34:29] second[40:35]
  // microsecond[60:41], zero fill [63:61]
  input  logic [cdjd_pkg::IN_BYTES*8-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // julian_day_us[59:0], zero fill [63:60]
  output logic [cdjd_pkg::OUT_BYTES*8-1:0] out_tdata,
  output logic        out_tuser    // gap_date
);
  import cdjd_pkg::*;

  localparam int unsigned STAGES = 6;

  logic signed [16:0] utc_off_r, utc_off_nxt;
  logic [STAGES-1:0]  vld_r, vld_nxt;
  logic [STAGES-1:0]  en;
  date_t              date;
  front_t             front;
  scale_t             scale;
  result_t            res;

  assign cfg_ready = 1'b1;
  assign utc_off_nxt = (cfg_valid && cfg_ready) ? $signed(cfg_data) : utc_off_r;

  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      utc_off_r <= '0;
    end else begin
      vld_r     <= vld_nxt;
      utc_off_r <= utc_off_nxt;
    end
  end

  assign date.year        = $signed(in_tdata[14:0]);
  assign date.month       = in_tdata[18:15];
  assign date.day         = in_tdata[23:19];
  assign date.hour        = in_tdata[28:24];
  assign date.minute      = in_tdata[34:29];
  assign date.second      = in_tdata[40:35];
  assign date.microsecond = in_tdata[60:41];

  cdjd_front u_front (
    .clk     (clk),
    .en      (en[1:0]),
    .date    (date),
    .utc_off (utc_off_r),
    .front   (front)
  );

  cdjd_scale u_scale (
    .clk   (clk),
    .en    (en[3:2]),
    .front (front),
    .scale (scale)
  );

  cdjd_final u_final (
    .clk   (clk),
    .en    (en[5:4]),
    .scale (scale),
    .res   (res)
  );

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {{(OUT_BYTES*8-60){1'b0}}, res.julian_day_us};
  assign out_tuser  = res.gap_date;

endmodule
